FILE: rtl/core/pbra_pkg.sv
// Shared types and constants for the page bitmap run allocator.
`default_nettype none

package pbra_pkg;

   localparam int WORD_BITS  = 8;
   localparam int WORD_SEL_W = 3;
   localparam int PAGE_W     = 20;
   localparam int COUNT_W    = 11;
   localparam int WIDE_W     = PAGE_W + 1;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_POOL0 = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_POOL1 = 1'b1;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE        = 2'd0,
      STAT_NO_SPACE    = 2'd1,
      STAT_OUT_OF_POOL = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_PLAN  = 7'b0001000,
      ST_SCAN  = 7'b0010000,
      ST_MARK  = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/page_bitmap_run_allocator.sv
// First-fit page run allocator over two pool occupancy bitmaps.
//
// Channels: req_ carries one request beat (allocate or free a run of pages),
// rsp_ returns exactly one result beat per request, csr_ writes the two pool
// base page registers (always ready, write only while no request is open).
// The bitmaps sit in one RAM of 8-bit words, one word read and one word
// written per cycle. An allocate walks the pool word by word, one word per
// cycle, checking eight pages per word; the found run is then marked with a
// read-modify-write pass of one word per cycle. A free passes the CHECK and
// PLAN states and then the same marking pass. One request is in the block at
// a time; req_tready is low from acceptance until the result beat is taken.
// A stalled rsp_tready holds the result and the block. After reset the block
// clears the bitmap RAM of both pools one word per cycle, with req_tready low;
// base registers reset to 0.
`default_nettype none

module page_bitmap_run_allocator #(
   parameter int POOL_PAGES = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [31:0]                      req_tdata,  // count, page_in
   input  wire logic [1:0]                       req_tuser,  // op, pool
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [23:0]                      rsp_tdata,  // page_out
   output logic      [1:0]                       rsp_tuser,  // status
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pbra_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pbra_pkg::PAGE_W-1:0]      csr_data
);

   import pbra_pkg::*;

   localparam int WPP   = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH = 2 * WPP;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = $clog2(WPP + 1);
   localparam int PW    = WW + WORD_SEL_W;

   state_type             state_ff, state_in;
   logic                  op_ff, op_in;
   logic                  pool_ff, pool_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [PAGE_W-1:0]     base0_ff, base0_in;
   logic [PAGE_W-1:0]     base1_ff, base1_in;
   logic [WIDE_W-1:0]     off_ff, off_in;
   logic                  below_ff, below_in;
   logic [PW-1:0]         lo_ff, lo_in;
   logic [PW-1:0]         last_ff, last_in;
   logic                  set_ff, set_in;
   logic [WW-1:0]         rd_cnt_ff, rd_cnt_in;
   logic                  pend_ff, pend_in;
   logic [WW-1:0]         rd_word_ff, rd_word_in;
   logic [PW-1:0]         run_ff, run_in;
   logic [AW-1:0]         clr_ff, clr_in;
   status_type            status_ff, status_in;
   logic [PAGE_W-1:0]     page_out_ff, page_out_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic                  ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [WORD_BITS-1:0]  ram_rdata;

   logic [PAGE_W-1:0]     base;
   logic [WW-1:0]         last_w;

   assign base   = pool_ff ? base1_ff : base0_ff;
   assign last_w = last_ff[PW-1:WORD_SEL_W];

   function automatic logic [AW-1:0] word_addr(input logic pool, input logic [WW-1:0] w);
      logic [AW-1:0] a;
      a = AW'(w);
      if (pool) begin
         a = a + AW'(WPP);
      end
      return a;
   endfunction

   pbra_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      logic [PW-1:0]        run_v;
      logic                 hit_v;
      logic [PW-1:0]        hit_pos_v;
      logic [PW-1:0]        pos_v;
      logic [WORD_BITS-1:0] mask_v;

      state_in    = state_ff;
      op_in       = op_ff;
      pool_in     = pool_ff;
      count_in    = count_ff;
      page_in     = page_ff;
      base0_in    = base0_ff;
      base1_in    = base1_ff;
      off_in      = off_ff;
      below_in    = below_ff;
      lo_in       = lo_ff;
      last_in     = last_ff;
      set_in      = set_ff;
      rd_cnt_in   = rd_cnt_ff;
      pend_in     = 1'b0;
      rd_word_in  = rd_word_ff;
      run_in      = run_ff;
      clr_in      = clr_ff;
      status_in   = status_ff;
      page_out_in = page_out_ff;

      ram_we    = 1'b0;
      ram_waddr = word_addr(pool_ff, rd_word_ff);
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = word_addr(pool_ff, rd_cnt_ff);

      run_v     = run_ff;
      hit_v     = 1'b0;
      hit_pos_v = '0;
      mask_v    = '0;

      for (int j = 0; j < WORD_BITS; j++) begin
         pos_v = {rd_word_ff, WORD_SEL_W'(j)};
         if (!hit_v) begin
            if (ram_rdata[j] || pos_v >= PW'(POOL_PAGES)) begin
               run_v = '0;
            end else begin
               run_v = run_v + 1'b1;
               if (run_v == PW'(count_ff)) begin
                  hit_v     = 1'b1;
                  hit_pos_v = pos_v;
               end
            end
         end
         mask_v[j] = (pos_v >= lo_ff) && (pos_v <= last_ff);
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_POOL0: base0_in = csr_data;
            CSR_BASE_POOL1: base1_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[0];
               pool_in  = req_tuser[1];
               count_in = req_tdata[COUNT_W-1:0];
               page_in  = req_tdata[COUNT_W +: PAGE_W];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            below_in    = page_ff < base;
            off_in      = {1'b0, page_ff} - {1'b0, base};
            page_out_in = '0;
            if (op_ff == OP_FREE) begin
               state_in = ST_PLAN;
            end else if (count_ff == '0 || WIDE_W'(count_ff) > WIDE_W'(POOL_PAGES)) begin
               status_in = STAT_NO_SPACE;
               state_in  = ST_RESP;
            end else begin
               rd_cnt_in = '0;
               run_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_PLAN: begin
            lo_in   = PW'(off_ff);
            last_in = PW'(off_ff) + PW'(count_ff) - 1'b1;
            set_in  = 1'b0;
            if (below_ff || off_ff > WIDE_W'(POOL_PAGES) ||
                WIDE_W'(count_ff) > WIDE_W'(POOL_PAGES) - off_ff) begin
               status_in = STAT_OUT_OF_POOL;
               state_in  = ST_RESP;
            end else if (count_ff == '0) begin
               status_in = STAT_DONE;
               state_in  = ST_RESP;
            end else begin
               rd_cnt_in = lo_in[PW-1:WORD_SEL_W];
               state_in  = ST_MARK;
            end
         end
         ST_SCAN: begin
            if (rd_cnt_ff < WW'(WPP)) begin
               ram_re     = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               rd_word_in = rd_cnt_ff;
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               run_in = run_v;
               if (hit_v) begin
                  lo_in     = hit_pos_v - PW'(count_ff) + 1'b1;
                  last_in   = hit_pos_v;
                  set_in    = 1'b1;
                  rd_cnt_in = lo_in[PW-1:WORD_SEL_W];
                  pend_in   = 1'b0;
                  state_in  = ST_MARK;
               end else if (rd_word_ff == WW'(WPP - 1)) begin
                  status_in = STAT_NO_SPACE;
                  pend_in   = 1'b0;
                  state_in  = ST_RESP;
               end
            end
         end
         ST_MARK: begin
            if (rd_cnt_ff <= last_w) begin
               ram_re     = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               rd_word_in = rd_cnt_ff;
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_wdata = set_ff ? (ram_rdata | mask_v) : (ram_rdata & ~mask_v);
               if (rd_word_ff == last_w) begin
                  pend_in     = 1'b0;
                  status_in   = STAT_DONE;
                  page_out_in = set_ff ? base + PAGE_W'(lo_ff) : '0;
                  state_in    = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
         clr_ff   <= '0;
         base0_ff <= '0;
         base1_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         clr_ff   <= clr_in;
         base0_ff <= base0_in;
         base1_ff <= base1_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pool_ff     <= pool_in;
      count_ff    <= count_in;
      page_ff     <= page_in;
      off_ff      <= off_in;
      below_ff    <= below_in;
      lo_ff       <= lo_in;
      last_ff     <= last_in;
      set_ff      <= set_in;
      rd_cnt_ff   <= rd_cnt_in;
      rd_word_ff  <= rd_word_in;
      run_ff      <= run_in;
      status_ff   <= status_in;
      page_out_ff <= page_out_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {4'b0000, page_out_ff};
   assign rsp_tuser  = status_ff;
   assign csr_ready  = 1'b1;

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and result channels open together");

   a_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_DONE) |-> (rsp_tdata == '0))
      else $error("failed result carries a page number");

   a_no_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("bitmap word read and written in the same cycle");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request taken before bitmap clear");

   a_take_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("block not ready after result taken");

endmodule

`default_nettype wire

FILE: rtl/core/pbra_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module pbra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: tb/page_bitmap_run_allocator_checker.sv
// Scoreboard for the page bitmap run allocator: tracks both pool maps and checks each result beat.
module page_bitmap_run_allocator_checker #(
   parameter int POOL_PAGES = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [31:0]                    req_tdata,  // count, page_in
   input  wire logic [1:0]                     req_tuser,  // op, pool
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [23:0]                    rsp_tdata,  // page_out
   input  wire logic [1:0]                     rsp_tuser,  // status
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [pbra_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pbra_pkg::PAGE_W-1:0]    csr_data,
   output int                                  fail_count,
   output int                                  open_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import pbra_pkg::*;

   typedef struct packed {
      status_type        status;
      logic [PAGE_W-1:0] page;
   } page_result_type;

   bit                pool_map [2][POOL_PAGES];
   logic [PAGE_W-1:0] pool_base [2];
   page_result_type   awaited_results [$];
   int                mismatches = 0;
   int                outstanding = 0;

   assign fail_count   = mismatches;
   assign open_results = outstanding;

   task automatic report_mismatch(string what);
      $display("[checker] %0t ns: %s", $time, what);
      mismatches++;
   endtask

   function automatic page_result_type serve_request(op_type op, bit psel,
                                                     logic [COUNT_W-1:0] count,
                                                     logic [PAGE_W-1:0] page);
      page_result_type res;
      int              run;
      int              start;
      int              off;
      bit              found;
      res.status = STAT_DONE;
      res.page   = '0;
      run        = 0;
      start      = 0;
      found      = 1'b0;
      if (op == OP_ALLOC) begin
         if (count != 0 && count <= POOL_PAGES) begin
            for (int i = 0; i < POOL_PAGES && !found; i++) begin
               if (pool_map[psel][i]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == count) begin
                     start = i + 1 - int'(count);
                     found = 1'b1;
                  end
               end
            end
         end
         if (found) begin
            for (int k = 0; k < count; k++) pool_map[psel][start + k] = 1'b1;
            res.page = PAGE_W'(pool_base[psel] + start);
         end else begin
            res.status = STAT_NO_SPACE;
         end
      end else if (page < pool_base[psel]) begin
         res.status = STAT_OUT_OF_POOL;
      end else begin
         off = int'(page) - int'(pool_base[psel]);
         if (off > POOL_PAGES || int'(count) > POOL_PAGES - off) begin
            res.status = STAT_OUT_OF_POOL;
         end else begin
            for (int k = 0; k < count; k++) pool_map[psel][off + k] = 1'b0;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      page_result_type want;
      if (reset) begin
         foreach (pool_map[p, i]) pool_map[p][i] = 1'b0;
         pool_base[0] = '0;
         pool_base[1] = '0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BASE_POOL0) pool_base[0] = csr_data;
            else pool_base[1] = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result beat with no request open");
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_tuser, want.status.name()));
               if (rsp_tdata[PAGE_W-1:0] !== want.page)
                  report_mismatch($sformatf("page_out %05h, expected %05h",
                                            rsp_tdata[PAGE_W-1:0], want.page));
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(serve_request(op_type'(req_tuser[0]), req_tuser[1],
                                                    req_tdata[COUNT_W-1:0],
                                                    req_tdata[COUNT_W +: PAGE_W]));
      end
      outstanding = awaited_results.size();
   end

endmodule

FILE: tb/page_bitmap_run_allocator_tb.sv
// Testbench top for the page bitmap run allocator: clock, reset, stimulus, flow control, verdict.
module page_bitmap_run_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbra_pkg::*;

   localparam int POOL_PAGES  = 1024;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [PAGE_W-1:0] DIR_BASE0 = 20'h00100;
   localparam logic [PAGE_W-1:0] DIR_BASE1 = 20'hFFE00;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   wire logic            req_tready;
   logic [31:0]          req_tdata = '0;  // count, page_in
   logic [1:0]           req_tuser = '0;  // op, pool
   wire logic            rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   wire logic [23:0]     rsp_tdata;       // page_out
   wire logic [1:0]      rsp_tuser;       // status
   logic                 csr_valid = 1'b0;
   wire logic            csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PAGE_W-1:0]    csr_data = '0;

   int                   fail_count;
   int                   open_results;
   bit                   steady = 1'b0;
   bit                   hold_rsp = 1'b0;
   logic [PAGE_W-1:0]    pool_base_now [2];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   page_bitmap_run_allocator #(.POOL_PAGES(POOL_PAGES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   page_bitmap_run_allocator_checker #(.POOL_PAGES(POOL_PAGES)) scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .open_results(open_results)
   );

   task automatic send_request(op_type op, bit psel, int count, int page);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, PAGE_W'(page), COUNT_W'(count)};
      req_tuser  <= {psel, op};
      do @(posedge clock); while (!req_tready);
      gap = steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_bases(int base0, int base1);
      csr_valid <= 1'b1;
      csr_index <= CSR_BASE_POOL0;
      csr_data  <= PAGE_W'(base0);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_BASE_POOL1;
      csr_data  <= PAGE_W'(base1);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_base_now[0] = PAGE_W'(base0);
      pool_base_now[1] = PAGE_W'(base1);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
   endtask

   task automatic churn_pools(int items, int alloc_pct);
      int  pick;
      int  kind;
      int  off;
      int  lim;
      int  cnt;
      bit  psel;
      for (int n = 0; n < items; n++) begin
         psel = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) cnt = $urandom_range(0, 2047);
            else if (kind == 1) cnt = $urandom_range(512, POOL_PAGES);
            else cnt = $urandom_range(1, 48);
            send_request(OP_ALLOC, psel, cnt, $urandom());
         end else if (pick < 90) begin
            off = $urandom_range(0, POOL_PAGES);
            lim = POOL_PAGES - off;
            if (lim > 64) lim = 64;
            cnt = $urandom_range(0, lim);
            if ($urandom_range(0, 29) == 0) begin
               off = 0;
               cnt = POOL_PAGES;
            end
            send_request(OP_FREE, psel, cnt, pool_base_now[psel] + off);
         end else begin
            send_request(OP_FREE, psel, $urandom_range(0, 2047), $urandom());
         end
      end
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = steady ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[page_bitmap_run_allocator] ERROR");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_bases(DIR_BASE0, DIR_BASE1);
      send_request(OP_ALLOC, 1'b0, 0, 20'h00000);
      send_request(OP_ALLOC, 1'b0, POOL_PAGES + 1, 20'hFFFFF);
      send_request(OP_ALLOC, 1'b0, 2047, 20'h00000);
      send_request(OP_ALLOC, 1'b0, 1, 20'h00000);
      send_request(OP_ALLOC, 1'b0, POOL_PAGES, 20'h00000);
      send_request(OP_FREE,  1'b0, 1, DIR_BASE0);
      send_request(OP_ALLOC, 1'b0, POOL_PAGES, 20'h00000);
      send_request(OP_ALLOC, 1'b0, 1, 20'h00000);
      send_request(OP_FREE,  1'b0, 1, DIR_BASE0 - 1);
      send_request(OP_FREE,  1'b0, 25, DIR_BASE0 + 1000);
      send_request(OP_FREE,  1'b0, 0, DIR_BASE0 + POOL_PAGES);
      send_request(OP_FREE,  1'b0, 0, DIR_BASE0 + POOL_PAGES + 1);
      send_request(OP_FREE,  1'b0, POOL_PAGES, DIR_BASE0);
      send_request(OP_FREE,  1'b0, 3, DIR_BASE0 + 5);
      send_request(OP_ALLOC, 1'b1, 600, 20'h00000);
      send_request(OP_ALLOC, 1'b1, 300, 20'h00000);
      send_request(OP_ALLOC, 1'b1, 200, 20'h00000);
      send_request(OP_FREE,  1'b1, 50, DIR_BASE1 + 100);
      send_request(OP_ALLOC, 1'b1, 40, 20'h00000);
      send_request(OP_ALLOC, 1'b1, 20, 20'h00000);
      send_request(OP_FREE,  1'b1, 2047, 20'hFFFFF);
      send_request(OP_FREE,  1'b1, POOL_PAGES, DIR_BASE1);
      drain_results();

      set_bases(20'h00000, 20'h00000);
      churn_pools(250, 55);
      drain_results();

      set_bases(20'hFFFFF, 20'hFFFFF);
      steady = 1'b1;
      churn_pools(150, 60);
      steady = 1'b0;
      drain_results();

      set_bases($urandom(), $urandom());
      hold_rsp = 1'b1;
      churn_pools(250, 65);
      drain_results();

      set_bases(20'hFFC00, 20'h00400);
      churn_pools(250, 50);
      drain_results();

      set_bases($urandom(), 20'hFFE80);
      churn_pools(230, 70);
      drain_results();

      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("[page_bitmap_run_allocator] OK");
      else $display("[page_bitmap_run_allocator] ERROR");
      $finish;
   end

endmodule
